>>> sv/shcs_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the sensor health and calibration supervisor.
// No dependencies; imported by every module of the block.
package shcs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam logic [WORD_W-1:0] U32_MAX = {WORD_W{1'b1}};
    localparam int unsigned CAL_FRACTION_SHIFT = 2;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_CAL_START = 2'd1,
        CMD_CAL_STOP  = 2'd2
    } t_cmd;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNCHANGED = 2'd1;

    localparam logic [1:0] CFG_POLL    = 2'd0;
    localparam logic [1:0] CFG_INVALID = 2'd1;
    localparam logic [1:0] CFG_RESET   = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] poll_interval_ms;
        logic [WORD_W-1:0] invalid_interval_ms;
        logic [WORD_W-1:0] reset_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        update_status;
        logic              cal_step_done;
        logic              saved_cal_valid;
        logic [WORD_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic              data_ok;
        logic              healthy;
        logic              health_lost;
        logic              calibrating;
        logic              calibrated;
        logic [WORD_W-1:0] cal_tick_index;
        logic              reinit_request;
    } t_result;

endpackage

>>> sv/sensor_health_calibration_supervisor.sv
`timescale 1ns / 1ps
// Top level of the sensor health and calibration supervisor: input and result registers.
// Depends on shcs_pkg, shcs_cfg and shcs_core.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+---------------------------------------------
//  in      | i_in_valid  | o_in_ready   | i_cmd, i_update_status, i_cal_step_done,
//          |             |              | i_saved_cal_valid, i_now_ms
//  out     | o_out_valid | i_out_ready  | o_data_ok, o_healthy, o_health_lost,
//          |             |              | o_calibrating, o_calibrated, o_cal_tick_index,
//          |             |              | o_reinit_request
//  cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken and no register write blocks input;
// the transfer loads the input register, then the result register once the output is free.
// Any register write blocks input in its own cycle; a poll interval write also blocks the
// cycle after it while the interval products reload through the multipliers.
// Reset is synchronous, active low; configuration returns to 10, 1000 and 5000 ms.
// A stalled result holds the result register; input is taken while the input register drains.
module sensor_health_calibration_supervisor
    import shcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_update_status,
    input  logic              i_cal_step_done,
    input  logic              i_saved_cal_valid,
    input  logic [WORD_W-1:0] i_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_data_ok,
    output logic              o_healthy,
    output logic              o_health_lost,
    output logic              o_calibrating,
    output logic              o_calibrated,
    output logic [WORD_W-1:0] o_cal_tick_index,
    output logic              o_reinit_request,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    reload;
    logic    adv;
    t_result res;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready) && !reload;
    assign o_in_ready  = (!r_in_valid || adv) && !reload && !i_cfg_valid;

    shcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_reload    (reload)
    );

    shcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_reload (reload),
        .i_adv    (adv),
        .i_item   (r_item),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.cmd             <= i_cmd;
            r_item.update_status   <= i_update_status;
            r_item.cal_step_done   <= i_cal_step_done;
            r_item.saved_cal_valid <= i_saved_cal_valid;
            r_item.now_ms          <= i_now_ms;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_ok        = r_res.data_ok;
    assign o_healthy        = r_res.healthy;
    assign o_health_lost    = r_res.health_lost;
    assign o_calibrating    = r_res.calibrating;
    assign o_calibrated     = r_res.calibrated;
    assign o_cal_tick_index = r_res.cal_tick_index;
    assign o_reinit_request = r_res.reinit_request;

endmodule

>>> sv/shcs_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and the product reload strobe after a poll interval write.
// Depends on shcs_pkg.
module shcs_cfg
    import shcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data,
    output t_cfg              o_cfg,
    output logic              o_reload
);

    t_cfg r_cfg;
    logic r_reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_ms    <= WORD_W'(10);
            r_cfg.invalid_interval_ms <= WORD_W'(1000);
            r_cfg.reset_interval_ms   <= WORD_W'(5000);
            r_reload                  <= 1'b0;
        end else begin
            r_reload <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POLL: begin
                        r_cfg.poll_interval_ms <= i_cfg_data;
                        r_reload               <= 1'b1;
                    end
                    CFG_INVALID: r_cfg.invalid_interval_ms <= i_cfg_data;
                    CFG_RESET:   r_cfg.reset_interval_ms   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg    = r_cfg;
    assign o_reload = r_reload;

endmodule

>>> sv/shcs_core.sv
`timescale 1ns / 1ps
// Supervisor state, running interval products and the per-item update logic.
// Depends on shcs_pkg.
module shcs_core
    import shcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_reload,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_res
);

    logic [WORD_W-1:0] r_bad_tick_count, n_bad_tick_count;
    logic [PROD_W-1:0] r_bad_prod, n_bad_prod;
    logic              r_last_ok_flag, n_last_ok_flag;
    logic              r_cal_running, n_cal_running;
    logic              r_cal_done, n_cal_done;
    logic [WORD_W-1:0] r_cal_step_count, n_cal_step_count;
    logic [WORD_W-1:0] r_cal_bad_count, n_cal_bad_count;
    logic [PROD_W-1:0] r_cal_prod, n_cal_prod;
    logic [WORD_W-1:0] r_last_reinit_ms, n_last_reinit_ms;

    logic [PROD_W-1:0] poll_ext;
    logic [PROD_W-1:0] invalid_ext;
    logic [PROD_W-1:0] cal_limit;
    logic [WORD_W-1:0] since_ms;
    logic              healthy_before;
    logic              healthy_after;
    logic              ok;
    t_result           res;

    assign poll_ext    = {{WORD_W{1'b0}}, i_cfg.poll_interval_ms};
    assign invalid_ext = {{WORD_W{1'b0}}, i_cfg.invalid_interval_ms};
    assign cal_limit   = {{WORD_W{1'b0}}, i_cfg.invalid_interval_ms >> CAL_FRACTION_SHIFT};
    assign since_ms    = i_item.now_ms - r_last_reinit_ms;
    assign healthy_before = r_bad_prod < invalid_ext;
    assign ok = (i_item.update_status == STAT_OK) || (i_item.update_status == STAT_UNCHANGED);

    always_comb begin
        n_bad_tick_count = r_bad_tick_count;
        n_bad_prod       = r_bad_prod;
        n_last_ok_flag   = r_last_ok_flag;
        n_cal_running    = r_cal_running;
        n_cal_done       = r_cal_done;
        n_cal_step_count = r_cal_step_count;
        n_cal_bad_count  = r_cal_bad_count;
        n_cal_prod       = r_cal_prod;
        n_last_reinit_ms = r_last_reinit_ms;
        res              = '0;
        healthy_after    = healthy_before;

        case (i_item.cmd)
            CMD_TICK: begin
                n_last_ok_flag = ok;
                if (ok && r_cal_running) begin
                    res.cal_tick_index = r_cal_step_count;
                    if (r_cal_step_count != U32_MAX) begin
                        n_cal_step_count = r_cal_step_count + 1'b1;
                    end
                    if (i_item.cal_step_done) begin
                        n_cal_done    = 1'b1;
                        n_cal_running = 1'b0;
                    end
                end
                if (i_item.update_status != STAT_OK) begin
                    if (r_bad_tick_count != U32_MAX) begin
                        n_bad_tick_count = r_bad_tick_count + 1'b1;
                        n_bad_prod       = r_bad_prod + poll_ext;
                    end
                    if (n_cal_running) begin
                        if (r_cal_bad_count != U32_MAX) begin
                            n_cal_bad_count = r_cal_bad_count + 1'b1;
                            n_cal_prod      = r_cal_prod + poll_ext;
                        end
                        if (n_cal_prod > cal_limit) begin
                            n_cal_done    = 1'b0;
                            n_cal_running = 1'b0;
                        end
                    end
                end else begin
                    n_bad_tick_count = '0;
                    n_bad_prod       = '0;
                end
                healthy_after = n_bad_prod < invalid_ext;
                if (!healthy_after) begin
                    res.health_lost = healthy_before;
                    if (since_ms > i_cfg.reset_interval_ms) begin
                        res.reinit_request = 1'b1;
                        n_last_reinit_ms   = i_item.now_ms;
                    end
                end
            end
            CMD_CAL_START: begin
                n_cal_done       = i_item.saved_cal_valid;
                n_cal_running    = 1'b1;
                n_cal_step_count = '0;
                n_cal_bad_count  = '0;
                n_cal_prod       = '0;
            end
            CMD_CAL_STOP: begin
                n_cal_running = 1'b0;
            end
            default: ;
        endcase

        res.data_ok     = n_last_ok_flag;
        res.healthy     = healthy_after;
        res.calibrating = n_cal_running;
        res.calibrated  = n_cal_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_tick_count <= '0;
            r_bad_prod       <= '0;
            r_last_ok_flag   <= 1'b0;
            r_cal_running    <= 1'b0;
            r_cal_done       <= 1'b0;
            r_cal_step_count <= '0;
            r_cal_bad_count  <= '0;
            r_cal_prod       <= '0;
            r_last_reinit_ms <= '0;
        end else if (i_reload) begin
            r_bad_prod <= {{WORD_W{1'b0}}, r_bad_tick_count} * poll_ext;
            r_cal_prod <= {{WORD_W{1'b0}}, r_cal_bad_count} * poll_ext;
        end else if (i_adv) begin
            r_bad_tick_count <= n_bad_tick_count;
            r_bad_prod       <= n_bad_prod;
            r_last_ok_flag   <= n_last_ok_flag;
            r_cal_running    <= n_cal_running;
            r_cal_done       <= n_cal_done;
            r_cal_step_count <= n_cal_step_count;
            r_cal_bad_count  <= n_cal_bad_count;
            r_cal_prod       <= n_cal_prod;
            r_last_reinit_ms <= n_last_reinit_ms;
        end
    end

    assign o_res = res;

    a_bad_prod_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad_tick_count == '0 |-> r_bad_prod == '0)
        else $error("bad tick product not zero with zero count");

    a_cal_prod_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_bad_count == '0 |-> r_cal_prod == '0)
        else $error("calibration product not zero with zero count");

    a_cal_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_reload && i_item.cmd == CMD_CAL_START |=> r_cal_running)
        else $error("calibration not running after start");

    a_reinit_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_reload && res.reinit_request |=> r_last_reinit_ms == $past(i_item.now_ms))
        else $error("re-init time stamp not taken");

endmodule
